FILE: rtl/core/lst_pkg.sv
// Package with the item types, timing constants and state type of the scanline timing controller.
package lst_pkg;

  // Timing constants.
  localparam logic [9:0] LINE_CYCLES    = 10'd456;
  localparam logic [7:0] VISIBLE_LINES  = 8'd144;
  localparam logic [7:0] TOTAL_LINES    = 8'd154;
  localparam logic [9:0] OAM_END_CYCLE  = 10'd81;
  localparam logic [9:0] XFER_END_CYCLE = 10'd253;

  // Display mode codes.
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  // One input item.
  typedef struct packed {
    logic [5:0] elapsed_cycles;
    logic [7:0] compare_line;
    logic       display_enable;
    logic       compare_irq_enable;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [1:0] current_mode;
    logic [7:0] current_line;
    logic       line_match;
    logic       vblank_irq;
    logic       compare_irq;
    logic       render_request;
    logic [7:0] render_line;
  } out_t;

  // Timing state carried from item to item.
  typedef struct packed {
    logic [9:0] cycle_sum;
    logic [7:0] line_count;
    logic       line_rendered;
    logic       frame_signalled;
    logic       match_flag;
  } state_t;

endpackage

FILE: rtl/core/lst_step.sv
// Combinational update of the timing state and result for one item.
module lst_step (
  input  lst_pkg::state_t state_cur,
  input  lst_pkg::in_t    item,
  output lst_pkg::state_t state_nxt,
  output lst_pkg::out_t   result
);
  import lst_pkg::*;

  logic [9:0] sum;
  logic [7:0] line_inc;
  logic       visible;
  logic       line_end;
  logic       frame_end;
  logic       req;
  logic       vbl;
  logic       match;
  mode_t      mode;

  always_comb begin
    // Add the elapsed cycles; the sum stays below 519.
    sum     = state_cur.cycle_sum + {4'd0, item.elapsed_cycles};
    visible = (state_cur.line_count < VISIBLE_LINES);

    // Mode is decided on the line before any advance.
    if (!visible) begin
      mode = MODE_VBLANK;
    end else if (sum < OAM_END_CYCLE) begin
      mode = MODE_OAM;
    end else if (sum < XFER_END_CYCLE) begin
      mode = MODE_XFER;
    end else begin
      mode = MODE_HBLANK;
    end

    // Render request once per visible line after pixel transfer time.
    req = (sum >= XFER_END_CYCLE) && visible && !state_cur.line_rendered;
    // Vblank interrupt once per frame, held off while the display is off.
    vbl = (state_cur.line_count == VISIBLE_LINES) && !state_cur.frame_signalled &&
          item.display_enable;

    // Line advance and frame wrap.
    line_end  = (sum >= LINE_CYCLES);
    line_inc  = state_cur.line_count + 8'd1;
    frame_end = line_end && (line_inc >= TOTAL_LINES);

    state_nxt                 = state_cur;
    state_nxt.cycle_sum       = line_end ? (sum - LINE_CYCLES) : sum;
    state_nxt.line_rendered   = line_end ? 1'b0 : (state_cur.line_rendered | req);
    state_nxt.frame_signalled = frame_end ? 1'b0 : (state_cur.frame_signalled | vbl);
    if (frame_end) begin
      state_nxt.line_count = '0;
    end else if (line_end) begin
      state_nxt.line_count = line_inc;
    end

    // Compare logic works on the line after the advance.
    match = (state_nxt.line_count == item.compare_line);
    result.compare_irq   = match && item.compare_irq_enable && !state_cur.match_flag;
    state_nxt.match_flag = match && (state_cur.match_flag | item.compare_irq_enable);

    result.current_mode   = mode;
    result.current_line   = state_nxt.line_count;
    result.line_match     = match;
    result.vblank_irq     = vbl;
    result.render_request = req;
    result.render_line    = req ? state_cur.line_count : 8'd0;
  end

endmodule

FILE: rtl/core/lcd_scanline_timing_controller.sv
// Top level of the LCD scanline timing controller: input register, step logic, result register.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready  | in_data  (lst_pkg::in_t)
//   out     | output    | out_valid / out_ready| out_data (lst_pkg::out_t)
//
// An item is held in the input register and then moves to the result register;
// one item is taken every cycle while the result register is not stalled.
// The timing state updates when an item moves from the input register to the
// result register. Synchronous active-low reset clears the state and both valids.
// A stalled result holds the output; the input register still takes one item if it is empty.
module lcd_scanline_timing_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lst_pkg::out_t out_data
);
  import lst_pkg::*;

  logic   in_valid_r;
  in_t    in_data_r;
  logic   out_valid_r;
  out_t   out_data_r;
  state_t state_r;
  state_t state_nxt;
  out_t   result;
  logic   step_fire;

  // The step runs when the input register is full and the result register is free.
  assign step_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_fire;

  lst_step u_step (
    .state_cur (state_r),
    .item      (in_data_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Timing state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
